>>> rtl/sliding_window_hit_counter_top_assert.svh
// Assertion macros for the sliding window hit counter checker.
`ifndef SLIDING_WINDOW_HIT_COUNTER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_HIT_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swhc_pkg.sv
// Shared types and constants of the sliding window hit counter.
`default_nettype none

package swhc_pkg;

    localparam int TS_W    = 32;
    localparam int COUNT_W = 32;
    localparam int WIN_W   = 10;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;

    // Operation codes of an input item
    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic            is_query;
        logic [TS_W-1:0] timestamp;
    } item_t;

    // Head of the item queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

`default_nettype wire

>>> rtl/swhc_req_if.sv
// Request channel: one hit or query with its timestamp per transfer.
`default_nettype none

interface swhc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [swhc_pkg::TS_W-1:0] timestamp;

    modport source (output valid, output op, output timestamp, input ready);
    modport sink   (input valid, input op, input timestamp, output ready);
endinterface

`default_nettype wire

>>> rtl/swhc_rsp_if.sv
// Response channel: one hit total per transfer.
`default_nettype none

interface swhc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [swhc_pkg::COUNT_W-1:0] hit_total;

    modport source (output valid, output hit_total, input ready);
    modport sink   (input valid, input hit_total, output ready);
endinterface

`default_nettype wire

>>> rtl/swhc_front.sv
// Front end: accept request transfers, classify them and hold them in a two-entry queue.
`default_nettype none

module swhc_front (
    input  wire                   clk,
    input  wire                   rst_n,
    swhc_req_if.sink              req,
    input  wire                   pop,
    output swhc_pkg::queue_head_t head
);

    swhc_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            push;
    logic            do_pop;
    swhc_pkg::item_t new_item;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (cnt_reg != 2'd0);

    // Classify the incoming transfer
    always_comb
    begin
        new_item.is_query  = (req.op == swhc_pkg::OP_QUERY);
        new_item.timestamp = req.timestamp;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/swhc_back.sv
// Back end: evict aged entries, merge or append hits, answer queries.
`default_nettype none

module swhc_back #(
    parameter int QUEUE_DEPTH = 512
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire [swhc_pkg::WIN_W-1:0]          window,
    input  swhc_pkg::queue_head_t              head,
    output logic                               pop,
    swhc_rsp_if.source                         rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);
    localparam logic [swhc_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_EXEC  = 1'b1;

    function automatic logic [swhc_pkg::COUNT_W-1:0] sat_inc(
        input logic [swhc_pkg::COUNT_W-1:0] v
    );
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    logic [swhc_pkg::TS_W-1:0]    time_mem  [QUEUE_DEPTH];
    logic [swhc_pkg::COUNT_W-1:0] count_mem [QUEUE_DEPTH];

    logic                         state_reg;
    logic                         state_next;
    logic [IDX_W-1:0]             head_reg;
    logic [IDX_W-1:0]             head_next;
    logic [IDX_W-1:0]             tail_reg;
    logic [IDX_W-1:0]             tail_next;
    logic [IDX_W-1:0]             last_reg;
    logic [IDX_W-1:0]             last_next;
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic [swhc_pkg::COUNT_W-1:0] total_reg;
    logic [swhc_pkg::COUNT_W-1:0] total_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic [swhc_pkg::COUNT_W-1:0] out_total_reg;
    logic                         cur_query_reg;
    logic [swhc_pkg::TS_W-1:0]    cur_ts_reg;
    logic [swhc_pkg::TS_W-1:0]    newest_time_reg;
    logic [swhc_pkg::COUNT_W-1:0] newest_count_reg;
    logic [swhc_pkg::TS_W-1:0]    rd_time_reg;
    logic [swhc_pkg::COUNT_W-1:0] rd_count_reg;

    logic [IDX_W-1:0]             head_inc;
    logic [IDX_W-1:0]             tail_inc;
    logic [IDX_W-1:0]             rd_addr;
    logic [swhc_pkg::TS_W-1:0]    age;
    logic [swhc_pkg::COUNT_W-1:0] total_sub;
    logic [swhc_pkg::COUNT_W-1:0] merged_count;
    logic                         evict;
    logic                         out_free;
    logic                         finish;
    logic                         is_merge;
    logic                         do_merge;
    logic                         do_append;
    logic                         load_out;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    assign age       = cur_ts_reg - rd_time_reg;
    assign total_sub = (total_reg >= rd_count_reg) ? total_reg - rd_count_reg : '0;
    assign evict     = (state_reg == ST_EXEC) && (occ_reg != '0)
                       && (age >= {{(swhc_pkg::TS_W - swhc_pkg::WIN_W){1'b0}}, window});

    assign out_free  = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == ST_EXEC) && !evict && (!cur_query_reg || out_free);
    assign load_out  = finish && cur_query_reg;

    assign is_merge  = (occ_reg != '0) && (newest_time_reg == cur_ts_reg);
    assign do_merge  = finish && !cur_query_reg && is_merge;
    assign do_append = finish && !cur_query_reg && !is_merge && (occ_reg != FULL_OCC);
    assign merged_count = sat_inc(newest_count_reg);

    // Read the next head ahead while popping so evictions run one per cycle
    assign rd_addr = evict ? head_inc : head_reg;

    assign pop = (state_reg == ST_FETCH) && head.valid;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            ST_FETCH:
            begin
                if (head.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (evict)
                begin
                    total_next = total_sub;
                    head_next  = head_inc;
                    occ_next   = occ_reg - 1'b1;
                end
                else if (finish)
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_FETCH;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        if (do_merge)
        begin
            total_next = sat_inc(total_reg);
        end
        if (do_append)
        begin
            total_next = sat_inc(total_reg);
            last_next  = tail_reg;
            tail_next  = tail_inc;
            occ_next   = occ_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FETCH;
            head_reg      <= '0;
            tail_reg      <= '0;
            last_reg      <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            last_reg      <= last_next;
            occ_reg       <= occ_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_query_reg <= head.item.is_query;
            cur_ts_reg    <= head.item.timestamp;
        end
        if (load_out)
        begin
            out_total_reg <= total_reg;
        end
        if (do_merge)
        begin
            newest_count_reg <= merged_count;
        end
        if (do_append)
        begin
            newest_time_reg  <= cur_ts_reg;
            newest_count_reg <= {{(swhc_pkg::COUNT_W - 1){1'b0}}, 1'b1};
        end
    end

    // Entry time memory: written on append, read at the head
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            time_mem[tail_reg] <= cur_ts_reg;
        end
        rd_time_reg <= time_mem[rd_addr];
    end

    // Entry count memory: written on append or merge, read at the head
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            count_mem[tail_reg] <= {{(swhc_pkg::COUNT_W - 1){1'b0}}, 1'b1};
        end
        else if (do_merge)
        begin
            count_mem[last_reg] <= merged_count;
        end
        rd_count_reg <= count_mem[rd_addr];
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit_total = out_total_reg;

endmodule

`default_nettype wire

>>> rtl/sliding_window_hit_counter_top.sv
// Top level of the sliding window hit counter.
// Counts hits over a sliding time window. Each request transfer is a hit
// (op 0) or a query (op 1) with a non-decreasing 32-bit timestamp; each query
// yields one response transfer carrying the number of hits whose age
// (timestamp minus hit time, modulo 2^32) is below window_length, and a hit
// yields nothing. Hits sharing the newest timestamp share one entry, so up to
// QUEUE_DEPTH distinct timestamps are held; a hit needing a new entry while
// all are in use is dropped. Counts saturate at all ones. An item visits a
// fetch state (taken from the input queue with the head entry read) and an
// execute state, which evicts old entries at the head; the head read of the
// entry memory is registered. Request transfers are taken into a two-entry
// queue while the engine works, and a finished total waits in an output
// register, so only a second query stalls behind an untaken response. The
// entry memories need no clearing after reset: only occupied entries are ever
// used. window_length resets to 300; the user must write it via cfg_wr_en /
// cfg_wr_data only while the block is idle; the block does not enforce it.
`default_nettype none

module sliding_window_hit_counter_top #(
    parameter int QUEUE_DEPTH = 512
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_wr_en,
    input  wire [swhc_pkg::WIN_W-1:0] cfg_wr_data,
    swhc_req_if.sink                  req,
    swhc_rsp_if.source                rsp
);

    // Window length register
    logic [swhc_pkg::WIN_W-1:0] window_reg;
    logic [swhc_pkg::WIN_W-1:0] window_next;

    // Queue head toward the back end, and its pop
    swhc_pkg::queue_head_t q_head;
    logic                  q_pop;

    assign window_next = cfg_wr_en ? cfg_wr_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swhc_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    // Front: hold accepted transfers until the engine takes them
    swhc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (q_pop),
        .head  (q_head)
    );

    // Back: evict, merge or append, and drive the response register
    swhc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .window (window_reg),
        .head   (q_head),
        .pop    (q_pop),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire

>>> rtl/swhc_checker.sv
// Port-level checker for the sliding window hit counter, with its bind.
`default_nettype none

`include "sliding_window_hit_counter_top_assert.svh"

module swhc_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         req_valid,
    input wire                         req_ready,
    input wire                         req_op,
    input wire                         rsp_valid,
    input wire                         rsp_ready,
    input wire [swhc_pkg::COUNT_W-1:0] rsp_hit_total
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic       query_xfer;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       hit_seen_reg;
    logic       hit_seen_next;

    assign req_xfer   = req_valid && req_ready;
    assign rsp_xfer   = rsp_valid && rsp_ready;
    assign query_xfer = req_xfer && (req_op == swhc_pkg::OP_QUERY);

    assign pending_next  = pending_reg + {2'b00, query_xfer} - {2'b00, rsp_xfer};
    assign hit_seen_next = hit_seen_reg || (req_xfer && (req_op == swhc_pkg::OP_HIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 3'd0;
            hit_seen_reg <= 1'b0;
        end
        else
        begin
            pending_reg  <= pending_next;
            hit_seen_reg <= hit_seen_next;
        end
    end

    `SWHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit_total), "response changed while stalled")
    `SWHC_ASSERT_NOW(a_rsp_has_query, rsp_valid, pending_reg != 3'd0, "response without an outstanding query")
    `SWHC_ASSERT_NOW(a_ready_drop, $fell(req_ready), $past(req_xfer), "ready fell without a transfer")
    `SWHC_ASSERT_NOW(a_zero_before_hit, rsp_valid && !hit_seen_reg, rsp_hit_total == '0, "nonzero total before any hit")

endmodule

bind sliding_window_hit_counter_top swhc_checker u_swhc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_op        (req.op),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_hit_total (rsp.hit_total)
);

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the sliding window hit counter top level.
`timescale 1ns / 100ps

module tb;

    // Entry queue depth of the instance under test
    localparam int ENTRY_SLOTS = 512;
    // Longest run of cycles with no transfer on either channel before giving up.
    // The slowest correct stretch is a full queue eviction or the long output
    // hold, plus a long gap on each side.
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [swhc_pkg::WIN_W-1:0] cfg_wr_data;

    swhc_req_if req_ch ();
    swhc_rsp_if rsp_ch ();

    sliding_window_hit_counter_top #(
        .QUEUE_DEPTH (ENTRY_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Window predictor: one entry per distinct hit timestamp, oldest first,
    // with a hit count per entry and a saturating running total.
    // ------------------------------------------------------------------
    logic [swhc_pkg::TS_W-1:0]    slot_stamp[$];
    logic [swhc_pkg::COUNT_W-1:0] slot_hits[$];
    logic [swhc_pkg::COUNT_W-1:0] window_total;
    logic [swhc_pkg::WIN_W-1:0]   window_len;

    // Totals still owed by the block, oldest first
    logic [swhc_pkg::COUNT_W-1:0] totals_due[$];
    logic [swhc_pkg::COUNT_W-1:0] total_want;

    // Run bookkeeping
    int mismatches = 0;
    int totals_checked = 0;
    int hits_sent = 0;
    int windows_tried = 1;
    logic [swhc_pkg::TS_W-1:0] stamp_now;

    // Pacing controls shared by the sender, the receiver and the tests
    bit steady = 1'b0;
    int hold_request = 0;

    function automatic logic [swhc_pkg::COUNT_W-1:0] sat_bump(
        input logic [swhc_pkg::COUNT_W-1:0] v
    );
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one accepted item to the predicted window; queue a total on a query.
    function automatic void count_window(input logic op, input logic [swhc_pkg::TS_W-1:0] now);
        logic [swhc_pkg::TS_W-1:0] age;
        int last;
        // Drop head entries that have aged out; the age wraps modulo 2^32,
        // so a timestamp that went backwards clears old entries too.
        while (slot_stamp.size() > 0)
        begin
            age = now - slot_stamp[0];
            if (age < {{(swhc_pkg::TS_W - swhc_pkg::WIN_W){1'b0}}, window_len})
                break;
            window_total = (window_total >= slot_hits[0]) ? window_total - slot_hits[0] : '0;
            slot_stamp.delete(0);
            slot_hits.delete(0);
        end
        if (op == swhc_pkg::OP_QUERY)
        begin
            totals_due.push_back(window_total);
            return;
        end
        last = slot_stamp.size() - 1;
        // Merge with the newest entry when the timestamp repeats
        if (last >= 0 && slot_stamp[last] == now)
        begin
            slot_hits[last] = sat_bump(slot_hits[last]);
            window_total = sat_bump(window_total);
            return;
        end
        // A hit that needs a new entry while the queue is full is lost
        if (slot_stamp.size() < ENTRY_SLOTS)
        begin
            slot_stamp.push_back(now);
            slot_hits.push_back(1);
            window_total = sat_bump(window_total);
        end
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Drive at the falling edge, sample ready at the rising
    // edge. Valid stays high into the next item when there is no gap, so it
    // is never lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [swhc_pkg::TS_W-1:0] ts);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.timestamp <= ts;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // Transfer taken at this edge: advance the predictor
        count_window(op, ts);
        if (op == swhc_pkg::OP_HIT)
            hits_sent++;
    endtask

    // Close a phase with a query, then hold the sender until every owed
    // total has come back. The query leaves the engine only after all
    // earlier hits, so the block is idle once its total is taken.
    task automatic drain_block();
        send_item(swhc_pkg::OP_QUERY, stamp_now);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (totals_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write window_length on an idle block
    task automatic set_window(input logic [swhc_pkg::WIN_W-1:0] value);
        drain_block();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        window_len = value;
        windows_tried++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random ready with stalls, plus a long hold on request.
    // ------------------------------------------------------------------
    initial
    begin : rsp_pacing
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Compare each response transfer with the oldest owed total
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (totals_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected hit_total transfer, expected none, got %0d",
                         $time, rsp_ch.hit_total);
            end
            else
            begin
                total_want = totals_due[0];
                totals_due.delete(0);
                totals_checked++;
                if (rsp_ch.hit_total !== total_want)
                begin
                    mismatches++;
                    $display("%0t: hit_total mismatch, expected %0d, got %0d",
                             $time, total_want, rsp_ch.hit_total);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-picked sequence on the reset window, then the two
    // smallest windows.
    task automatic test_directed();
        // Empty queue, same-stamp merge, age just inside and just at the window
        send_item(swhc_pkg::OP_QUERY, 32'd0);
        send_item(swhc_pkg::OP_HIT,   32'd0);
        send_item(swhc_pkg::OP_HIT,   32'd0);
        send_item(swhc_pkg::OP_HIT,   32'd5);
        send_item(swhc_pkg::OP_QUERY, 32'd10);
        send_item(swhc_pkg::OP_QUERY, 32'd299);
        send_item(swhc_pkg::OP_QUERY, 32'd300);
        send_item(swhc_pkg::OP_HIT,   32'd305);
        send_item(swhc_pkg::OP_QUERY, 32'd305);
        // Top of the timestamp range and wrap past zero
        send_item(swhc_pkg::OP_HIT,   32'hFFFF_FFF0);
        send_item(swhc_pkg::OP_HIT,   32'hFFFF_FFFF);
        send_item(swhc_pkg::OP_QUERY, 32'h0000_0010);
        send_item(swhc_pkg::OP_HIT,   32'd100);
        send_item(swhc_pkg::OP_HIT,   32'd1000);
        // Timestamp going backwards: every entry looks ancient
        send_item(swhc_pkg::OP_QUERY, 32'd400);
        // Zero window: each item empties the queue first
        set_window('0);
        send_item(swhc_pkg::OP_HIT,   32'd7);
        send_item(swhc_pkg::OP_HIT,   32'd7);
        send_item(swhc_pkg::OP_QUERY, 32'd7);
        // One-unit window: only the current stamp counts
        set_window(10'd1);
        send_item(swhc_pkg::OP_HIT,   32'd8);
        send_item(swhc_pkg::OP_HIT,   32'd8);
        send_item(swhc_pkg::OP_QUERY, 32'd8);
        send_item(swhc_pkg::OP_QUERY, 32'd9);
        stamp_now = 32'd9;
    endtask

    // Fill every entry slot, overflow it, merge into the newest entry while
    // full, then evict the oldest entry and later all the rest in one go.
    task automatic test_full_queue();
        logic [swhc_pkg::TS_W-1:0] base;
        base = 32'h7FFF_FE00;
        set_window('1);
        for (int i = 0; i < ENTRY_SLOTS + 4; i++)
            send_item(swhc_pkg::OP_HIT, base + i);
        send_item(swhc_pkg::OP_HIT,   base + ENTRY_SLOTS - 1);
        send_item(swhc_pkg::OP_QUERY, base + ENTRY_SLOTS + 3);
        send_item(swhc_pkg::OP_QUERY, base + 1023);
        send_item(swhc_pkg::OP_QUERY, base + 2000);
        send_item(swhc_pkg::OP_HIT,   base + 2000);
        stamp_now = base + 2000;
    endtask

    // Hold the response side for a long stretch while requests keep coming,
    // so the input queue and output register fill and the input stalls.
    task automatic test_backpressure();
        set_window(10'd300);
        steady = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                stamp_now += $urandom_range(0, 20);
            send_item(($urandom_range(0, 2) != 0) ? swhc_pkg::OP_QUERY : swhc_pkg::OP_HIT,
                      stamp_now);
        end
        steady = 1'b0;
    endtask

    // One random item: mostly small forward steps and repeats, some long
    // jumps, and a few backward steps.
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            stamp_now = stamp_now;
        else if (r < 85)
            stamp_now += $urandom_range(1, window_len / 8 + 1);
        else if (r < 94)
            stamp_now += $urandom_range(window_len / 2, window_len + 2);
        else if (r < 97)
            stamp_now += $urandom();
        else
            stamp_now -= $urandom_range(1, 2000);
        send_item(($urandom_range(0, 9) < 3) ? swhc_pkg::OP_QUERY : swhc_pkg::OP_HIT,
                  stamp_now);
    endtask

    // Random traffic over a spread of window settings
    task automatic test_random_phases();
        logic [swhc_pkg::WIN_W-1:0] windows[8];
        windows = '{10'd300, 10'd1023, 10'd1, 10'd512, 10'd0, 10'd2, 10'd511, 10'd64};
        windows[7] = swhc_pkg::WIN_W'($urandom_range(3, 1022));
        for (int p = 0; p < 8; p++)
        begin
            set_window(windows[p]);
            stamp_now = $urandom();
            for (int i = 0; i < 170; i++)
            begin
                // Odd phases open with a stretch with no idling on either side
                steady = (p % 2 == 1) && (i < 40);
                random_item();
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = swhc_pkg::OP_HIT;
        req_ch.timestamp = '0;
        window_total     = '0;
        window_len       = swhc_pkg::WINDOW_RESET;
        stamp_now        = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_queue();
        test_backpressure();
        test_random_phases();

        // Flush the last results, then allow a few cycles for strays
        drain_block();
        repeat (16) @(posedge clk);

        $display("Sent %0d hits and checked %0d totals over %0d window settings,",
                 hits_sent, totals_checked, windows_tried);
        $display("including a full entry queue, wrapped timestamps and a long output hold.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
